[hw/rtl/semt_pkg.sv]
`default_nettype none
package semt_pkg;

	// one extent record as kept in the table
	typedef struct packed {
		logic [47:0] start;
		logic [47:0] addr;
		logic [15:0] len;
		logic        flag;
	} entry_t;

	// operation codes
	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_HOLE  = 3'd1;
	localparam logic [2:0] ST_FULL  = 3'd2;
	localparam logic [2:0] ST_RANGE = 3'd3;
	localparam logic [2:0] ST_OVF   = 3'd4;

	// table shift kinds
	localparam logic [1:0] GAP_NONE  = 2'd0;
	localparam logic [1:0] GAP_OPEN  = 2'd1;
	localparam logic [1:0] GAP_CLOSE = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic srch_rd;
		logic srch_upd;
		logic rd_cur;
		logic cap_cur;
		logic cap_nxt;
		logic prep;
		logic plan;
		logic gap_rd;
		logic gap_wr;
		logic wr0;
		logic wr1;
		logic done;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic srch_go;
		logic gap_go;
	} sts_t;

endpackage
`default_nettype wire

[hw/rtl/sorted_extent_map_table.sv]
// from start to the done beat: a binary search of k steps (at most clog2(count+1)),
//   then a table shift that moves m entries, then the writes and the result
// throughput: one operation at a time; busy stays high until the result beat
// the table memory has one registered read port, so each search step and each
//   shifted entry takes a read state and then a compare or write state
// reset clears the extent count and the control registers; table contents are undefined until written
// the done beat lasts one cycle and the receiver cannot stall
`default_nettype none
module sorted_extent_map_table #(
	parameter int EXTENTS = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire [1:0]   mode,
	input  wire [47:0]  block,
	input  wire [47:0]  phys_addr,
	input  wire [15:0]  length,
	input  wire         unwritten_in,
	output logic        done,
	output logic [2:0]  status,
	output logic [47:0] ext_start,
	output logic [47:0] ext_addr,
	output logic [15:0] ext_len,
	output logic        unwritten_out,
	output logic [47:0] next_start,
	output logic [6:0]  entry_total
);

	semt_pkg::cmd_t cmd;
	semt_pkg::sts_t sts;

	// sequencer
	semt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// table and arithmetic
	semt_dp #(
		.EXTENTS (EXTENTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (mode),
		.block         (block),
		.phys_addr     (phys_addr),
		.length        (length),
		.unwritten_in  (unwritten_in),
		.done          (done),
		.status        (status),
		.ext_start     (ext_start),
		.ext_addr      (ext_addr),
		.ext_len       (ext_len),
		.unwritten_out (unwritten_out),
		.next_start    (next_start),
		.entry_total   (entry_total)
	);

endmodule
`default_nettype wire

[hw/rtl/semt_ctrl.sv]
`default_nettype none
module semt_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  semt_pkg::sts_t   sts,
	output semt_pkg::cmd_t   cmd,
	output logic             busy
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCHK = 4'd1;
	localparam logic [3:0] S_SCMP = 4'd2;
	localparam logic [3:0] S_CUR  = 4'd3;
	localparam logic [3:0] S_NXT  = 4'd4;
	localparam logic [3:0] S_PREP = 4'd5;
	localparam logic [3:0] S_PLAN = 4'd6;
	localparam logic [3:0] S_GCHK = 4'd7;
	localparam logic [3:0] S_GWR  = 4'd8;
	localparam logic [3:0] S_WR0  = 4'd9;
	localparam logic [3:0] S_WR1  = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// next state and commands
	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_SCHK;
				end
			end
			S_SCHK: begin
				if (sts.srch_go) begin
					cmd.srch_rd = 1'b1;
					state_d = S_SCMP;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d = S_CUR;
				end
			end
			S_SCMP: begin
				cmd.srch_upd = 1'b1;
				state_d = S_SCHK;
			end
			S_CUR: begin
				cmd.cap_cur = 1'b1;
				state_d = S_NXT;
			end
			S_NXT: begin
				cmd.cap_nxt = 1'b1;
				state_d = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d = S_PLAN;
			end
			S_PLAN: begin
				cmd.plan = 1'b1;
				state_d = S_GCHK;
			end
			S_GCHK: begin
				if (sts.gap_go) begin
					cmd.gap_rd = 1'b1;
					state_d = S_GWR;
				end else begin
					state_d = S_WR0;
				end
			end
			S_GWR: begin
				cmd.gap_wr = 1'b1;
				state_d = S_GCHK;
			end
			S_WR0: begin
				cmd.wr0 = 1'b1;
				state_d = S_WR1;
			end
			S_WR1: begin
				cmd.wr1 = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.done = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

[hw/rtl/semt_dp.sv]
`default_nettype none
module semt_dp #(
	parameter int EXTENTS = 64
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  semt_pkg::cmd_t         cmd,
	output semt_pkg::sts_t         sts,
	input  wire [1:0]              mode,
	input  wire [47:0]             block,
	input  wire [47:0]             phys_addr,
	input  wire [15:0]             length,
	input  wire                    unwritten_in,
	output logic                   done,
	output logic [2:0]             status,
	output logic [47:0]            ext_start,
	output logic [47:0]            ext_addr,
	output logic [15:0]            ext_len,
	output logic                   unwritten_out,
	output logic [47:0]            next_start,
	output logic [6:0]             entry_total
);

	localparam int IW = $clog2(EXTENTS);
	localparam int CW = $clog2(EXTENTS + 1);

	typedef struct packed {
		logic [2:0]       status;
		semt_pkg::entry_t res;
		logic [47:0]      nx;
		logic [1:0]       gap;
		logic [CW-1:0]    gpos;
		logic             w0_en;
		logic [IW-1:0]    w0_idx;
		semt_pkg::entry_t w0;
		logic             w1_en;
		logic [IW-1:0]    w1_idx;
		semt_pkg::entry_t w1;
		logic [CW-1:0]    cnt_new;
	} plan_t;

	// table memory
	semt_pkg::entry_t mem [EXTENTS];
	semt_pkg::entry_t rd_q;
	logic             we;
	logic [IW-1:0]    wa;
	logic [IW-1:0]    ra;
	semt_pkg::entry_t wd;

	// operation and working registers
	logic [1:0]       mode_q;
	logic [47:0]      blk_q;
	logic [47:0]      pa_q;
	logic [15:0]      len_q;
	logic             uw_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    lo_q;
	logic [CW-1:0]    hi_q;
	logic [IW-1:0]    mid_q;
	logic [IW-1:0]    idx_q;
	semt_pkg::entry_t cur_q;
	semt_pkg::entry_t nxt_q;
	logic [48:0]      e0_q;
	logic [48:0]      bl_q;
	logic [48:0]      ae_q;
	logic [48:0]      al_q;
	logic [15:0]      off_q;
	plan_t            plan_q;
	plan_t            plan_d;
	logic [CW-1:0]    ptr_q;
	logic             done_q;
	logic [2:0]       st_q;
	semt_pkg::entry_t res_q;
	logic [47:0]      nx_q;
	logic [6:0]       total_q;

	// search and address helpers
	logic [CW:0]      lohi;
	logic [IW-1:0]    mid_d;
	logic [CW-1:0]    lo_dn;
	logic [IW-1:0]    idx_d;
	logic [IW-1:0]    idx1;
	logic [CW-1:0]    ptr_dn;
	logic [CW:0]      ptr_up;
	logic [47:0]      diff;
	logic [CW+6:0]    total_ext;

	assign lohi   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_d  = lohi[IW:1];
	assign lo_dn  = lo_q - CW'(1);
	assign idx_d  = (lo_q == '0) ? '0 : lo_dn[IW-1:0];
	assign idx1   = idx_q + IW'(1);
	assign ptr_dn = ptr_q - CW'(1);
	assign ptr_up = {1'b0, ptr_q} + (CW+1)'(1);
	assign diff   = blk_q - cur_q.start;
	assign total_ext = {7'b0, plan_q.cnt_new};

	// status to controller
	always_comb begin
		sts.srch_go = (lo_q < hi_q);
		case (plan_q.gap)
			semt_pkg::GAP_OPEN:  sts.gap_go = (ptr_q > plan_q.gpos);
			semt_pkg::GAP_CLOSE: sts.gap_go = (ptr_up < {1'b0, cnt_q});
			default:             sts.gap_go = 1'b0;
		endcase
	end

	// read address select
	always_comb begin
		if (cmd.srch_rd) begin
			ra = mid_d;
		end else if (cmd.rd_cur) begin
			ra = idx_d;
		end else if (cmd.cap_cur) begin
			ra = idx1;
		end else if (cmd.gap_rd && plan_q.gap == semt_pkg::GAP_OPEN) begin
			ra = ptr_dn[IW-1:0];
		end else begin
			ra = ptr_up[IW-1:0];
		end
	end

	// write port select
	always_comb begin
		if (cmd.gap_wr) begin
			we = 1'b1;
			wa = ptr_q[IW-1:0];
			wd = rd_q;
		end else if (cmd.wr0) begin
			we = plan_q.w0_en;
			wa = plan_q.w0_idx;
			wd = plan_q.w0;
		end else if (cmd.wr1) begin
			we = plan_q.w1_en;
			wa = plan_q.w1_idx;
			wd = plan_q.w1;
		end else begin
			we = 1'b0;
			wa = plan_q.w0_idx;
			wd = plan_q.w0;
		end
	end

	// memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	// operation plan from the found extent and its right neighbor
	always_comb begin
		plan_t            p;
		logic             has_nxt;
		logic             empty;
		logic             full;
		logic             do_new;
		logic             right;
		logic [IW-1:0]    np;
		logic [CW-1:0]    idx1c;
		logic [16:0]      nl;
		logic [17:0]      nl2;
		logic [16:0]      tot;
		logic [16:0]      ol;
		semt_pkg::entry_t nw;
		p = '0;
		p.status = semt_pkg::ST_OK;
		p.gap = semt_pkg::GAP_NONE;
		p.cnt_new = cnt_q;
		idx1c = CW'(idx_q) + CW'(1);
		has_nxt = (idx1c < cnt_q);
		empty = (cnt_q == '0);
		full = (cnt_q == CW'(EXTENTS));
		do_new = 1'b0;
		right = 1'b0;
		np = idx_q;
		nl = {1'b0, cur_q.len} + {1'b0, len_q};
		nl2 = {1'b0, nl} + {2'b0, nxt_q.len};
		tot = '0;
		ol = {1'b0, off_q} + {1'b0, len_q};
		nw.start = blk_q;
		nw.addr = pa_q;
		nw.len = len_q;
		nw.flag = uw_q;
		case (mode_q)
			semt_pkg::MODE_LOOKUP: begin
				if (empty) begin
					p.status = semt_pkg::ST_HOLE;
				end else if (blk_q >= cur_q.start && {1'b0, blk_q} < e0_q) begin
					p.res = cur_q;
				end else begin
					p.status = semt_pkg::ST_HOLE;
					if (cur_q.start > blk_q) begin
						p.nx = cur_q.start;
					end else if (has_nxt) begin
						p.nx = nxt_q.start;
					end
				end
			end
			semt_pkg::MODE_INSERT: begin
				if (len_q == '0 || bl_q > {1'b1, 48'b0}) begin
					p.status = semt_pkg::ST_RANGE;
				end else if (empty) begin
					do_new = 1'b1;
					np = '0;
				end else if ((cur_q.start <= blk_q) ?
						({1'b0, blk_q} < e0_q ||
						(has_nxt && {1'b0, nxt_q.start} < bl_q)) :
						({1'b0, cur_q.start} < bl_q)) begin
					p.status = semt_pkg::ST_RANGE;
				end else if (cur_q.start < blk_q) begin
					if (e0_q == {1'b0, blk_q} && ae_q == {1'b0, pa_q} &&
							cur_q.flag == uw_q) begin
						// merge onto the left extent, maybe also the right one
						right = has_nxt && bl_q == {1'b0, nxt_q.start} &&
							al_q == {1'b0, nxt_q.addr} && uw_q == nxt_q.flag;
						if (nl[16]) begin
							p.status = semt_pkg::ST_OVF;
						end else if (right) begin
							if (nl2[17:16] != 2'b0) begin
								p.status = semt_pkg::ST_OVF;
							end else begin
								p.w0_en = 1'b1;
								p.w0_idx = idx_q;
								p.w0 = cur_q;
								p.w0.len = nl2[15:0];
								p.res = p.w0;
								p.gap = semt_pkg::GAP_CLOSE;
								p.gpos = idx1c;
								p.cnt_new = cnt_q - CW'(1);
							end
						end else begin
							p.w0_en = 1'b1;
							p.w0_idx = idx_q;
							p.w0 = cur_q;
							p.w0.len = nl[15:0];
							p.res = p.w0;
						end
					end else if (has_nxt && bl_q == {1'b0, nxt_q.start} &&
							al_q == {1'b0, nxt_q.addr} && uw_q == nxt_q.flag) begin
						// prepend to the right extent
						tot = {1'b0, nxt_q.len} + {1'b0, len_q};
						if (tot[16]) begin
							p.status = semt_pkg::ST_OVF;
						end else begin
							p.w0_en = 1'b1;
							p.w0_idx = idx1;
							p.w0 = nw;
							p.w0.len = tot[15:0];
							p.res = p.w0;
						end
					end else begin
						do_new = 1'b1;
						np = idx1;
					end
				end else begin
					if (bl_q == {1'b0, cur_q.start} && al_q == {1'b0, cur_q.addr} &&
							uw_q == cur_q.flag) begin
						// prepend to the first extent
						tot = {1'b0, cur_q.len} + {1'b0, len_q};
						if (tot[16]) begin
							p.status = semt_pkg::ST_OVF;
						end else begin
							p.w0_en = 1'b1;
							p.w0_idx = idx_q;
							p.w0 = nw;
							p.w0.len = tot[15:0];
							p.res = p.w0;
						end
					end else begin
						do_new = 1'b1;
						np = idx_q;
					end
				end
				// new entry in order
				if (do_new) begin
					if (full) begin
						p.status = semt_pkg::ST_FULL;
					end else begin
						p.gap = semt_pkg::GAP_OPEN;
						p.gpos = CW'(np);
						p.w0_en = 1'b1;
						p.w0_idx = np;
						p.w0 = nw;
						p.res = nw;
						p.cnt_new = cnt_q + CW'(1);
					end
				end
			end
			semt_pkg::MODE_REMOVE: begin
				if (len_q == '0 || empty || blk_q < cur_q.start || bl_q > e0_q) begin
					p.status = semt_pkg::ST_RANGE;
				end else begin
					p.res.start = blk_q;
					p.res.addr = cur_q.addr + {32'b0, off_q};
					p.res.len = len_q;
					p.res.flag = cur_q.flag;
					if (blk_q == cur_q.start && bl_q == e0_q) begin
						// whole extent
						p.gap = semt_pkg::GAP_CLOSE;
						p.gpos = CW'(idx_q);
						p.cnt_new = cnt_q - CW'(1);
					end else if (blk_q == cur_q.start) begin
						// head
						p.w0_en = 1'b1;
						p.w0_idx = idx_q;
						p.w0.start = bl_q[47:0];
						p.w0.addr = cur_q.addr + {32'b0, len_q};
						p.w0.len = cur_q.len - len_q;
						p.w0.flag = cur_q.flag;
					end else if (bl_q == e0_q) begin
						// tail
						p.w0_en = 1'b1;
						p.w0_idx = idx_q;
						p.w0 = cur_q;
						p.w0.len = off_q;
					end else if (full) begin
						p.status = semt_pkg::ST_FULL;
						p.res = '0;
					end else begin
						// middle split
						p.gap = semt_pkg::GAP_OPEN;
						p.gpos = idx1c;
						p.w0_en = 1'b1;
						p.w0_idx = idx_q;
						p.w0 = cur_q;
						p.w0.len = off_q;
						p.w1_en = 1'b1;
						p.w1_idx = idx1;
						p.w1.start = bl_q[47:0];
						p.w1.addr = cur_q.addr + {31'b0, ol};
						p.w1.len = cur_q.len - ol[15:0];
						p.w1.flag = cur_q.flag;
						p.cnt_new = cnt_q + CW'(1);
					end
				end
			end
			default: begin
				p.status = semt_pkg::ST_OK;
			end
		endcase
		plan_d = p;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			blk_q  <= block;
			pa_q   <= phys_addr;
			len_q  <= length;
			uw_q   <= unwritten_in;
		end
		if (cmd.srch_rd) begin
			mid_q <= mid_d;
		end
		if (cmd.rd_cur) begin
			idx_q <= idx_d;
		end
		if (cmd.cap_cur) begin
			cur_q <= rd_q;
		end
		if (cmd.cap_nxt) begin
			nxt_q <= rd_q;
		end
		if (cmd.prep) begin
			e0_q  <= {1'b0, cur_q.start} + {33'b0, cur_q.len};
			bl_q  <= {1'b0, blk_q} + {33'b0, len_q};
			ae_q  <= {1'b0, cur_q.addr} + {33'b0, cur_q.len};
			al_q  <= {1'b0, pa_q} + {33'b0, len_q};
			off_q <= diff[15:0];
		end
		if (cmd.plan) begin
			plan_q <= plan_d;
		end
		if (cmd.done) begin
			st_q    <= plan_q.status;
			res_q   <= plan_q.res;
			nx_q    <= plan_q.nx;
			total_q <= total_ext[6:0];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			lo_q   <= '0;
			hi_q   <= '0;
			ptr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.done;
			if (cmd.load) begin
				lo_q <= '0;
				hi_q <= cnt_q;
			end
			if (cmd.srch_upd) begin
				if (rd_q.start <= blk_q) begin
					lo_q <= CW'(mid_q) + CW'(1);
				end else begin
					hi_q <= CW'(mid_q);
				end
			end
			if (cmd.plan) begin
				ptr_q <= (plan_d.gap == semt_pkg::GAP_OPEN) ? cnt_q : plan_d.gpos;
			end
			if (cmd.gap_wr) begin
				ptr_q <= (plan_q.gap == semt_pkg::GAP_OPEN) ? ptr_dn : ptr_up[CW-1:0];
			end
			if (cmd.done) begin
				cnt_q <= plan_q.cnt_new;
			end
		end
	end

	assign done          = done_q;
	assign status        = st_q;
	assign ext_start     = res_q.start;
	assign ext_addr      = res_q.addr;
	assign ext_len       = res_q.len;
	assign unwritten_out = res_q.flag;
	assign next_start    = nx_q;
	assign entry_total   = total_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(EXTENTS))
		else $error("extent count above table size");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.done |=> $stable(cnt_q))
		else $error("extent count changed outside completion");

	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		lo_q <= hi_q)
		else $error("search window inverted");

	a_shift_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gap_wr |-> ptr_q < CW'(EXTENTS))
		else $error("shift write beyond table");

endmodule
`default_nettype wire
